### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SME_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define SME_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/sme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sme_pkg;

    localparam int FIELD_W = 3;
    localparam int TYPE_W  = 2;
    localparam int MAX_OUT = 8;

    typedef enum logic [TYPE_W-1:0] {
        REQ_LOAD_PREF = 2'd0,
        REQ_LOAD_RANK = 2'd1,
        REQ_RUN       = 2'd2
    } req_kind_t;

    typedef struct packed {
        req_kind_t            kind;
        logic [FIELD_W-1:0]   person;
        logic [FIELD_W-1:0]   rank;
        logic [FIELD_W-1:0]   choice;
    } sme_cmd_t;

endpackage

`default_nettype wire

### hdl/sme_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface sme_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [2:0] person;
    logic [2:0] rank;
    logic [2:0] choice;

    modport source (output valid, output req_type, output person, output rank,
                    output choice, input ready);
    modport sink   (input valid, input req_type, input person, input rank,
                    input choice, output ready);
endinterface

interface sme_pair_if;
    logic       valid;
    logic       ready;
    logic [2:0] proposer;
    logic [2:0] partner;
    logic       unmatched;
    logic       last_pair;

    modport source (output valid, output proposer, output partner, output unmatched,
                    output last_pair, input ready);
    modport sink   (input valid, input proposer, input partner, input unmatched,
                    input last_pair, output ready);
endinterface

`default_nettype wire

### hdl/sme_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sme_front #(
    parameter int NUM_PEOPLE = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    sme_req_if.sink            req,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output sme_pkg::sme_cmd_t  cmd
);
    import sme_pkg::*;

    localparam int Q_DEPTH = 2;

    sme_cmd_t   q_reg [Q_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       keep;
    logic       push;
    logic       pop;
    sme_cmd_t   in_cmd;

    // loads with an index past the table and unknown types are dropped here
    always_comb
    begin
        unique case (req.req_type)
            REQ_LOAD_PREF, REQ_LOAD_RANK:
                keep = (int'(req.person) < NUM_PEOPLE) && (int'(req.rank) < NUM_PEOPLE)
                       && (int'(req.choice) < NUM_PEOPLE);
            REQ_RUN:
                keep = 1'b1;
            default:
                keep = 1'b0;
        endcase
    end

    assign in_cmd.kind   = req_kind_t'(req.req_type);
    assign in_cmd.person = req.person;
    assign in_cmd.rank   = req.rank;
    assign in_cmd.choice = req.choice;

    assign req.ready = (cnt_reg != 2'(Q_DEPTH));
    assign push      = req.valid && req.ready && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/sme_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sme_back #(
    parameter int NUM_PEOPLE = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire sme_pkg::sme_cmd_t  cmd,
    sme_pair_if.source              pair
);
    import sme_pkg::*;

    localparam int IDX_W   = $clog2(NUM_PEOPLE);
    localparam int POS_W   = $clog2(NUM_PEOPLE + 1);
    localparam int DEPTH   = NUM_PEOPLE * NUM_PEOPLE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int OUT_CNT = (NUM_PEOPLE < MAX_OUT) ? NUM_PEOPLE : MAX_OUT;
    localparam int CNT_W   = $clog2(OUT_CNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_PREF,
        S_CMP,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [NUM_PEOPLE-1:0]  free_reg;
    logic [NUM_PEOPLE-1:0]  pm_reg;
    logic [NUM_PEOPLE-1:0]  ae_reg;
    logic [IDX_W-1:0]       pp_reg  [NUM_PEOPLE];
    logic [IDX_W-1:0]       ap_reg  [NUM_PEOPLE];
    logic [POS_W-1:0]       pos_reg [NUM_PEOPLE];
    logic [IDX_W-1:0]       cur_p_reg;
    logic [IDX_W-1:0]       cur_a_reg;
    logic [IDX_W-1:0]       rival_reg;
    logic [CNT_W-1:0]       cnt_reg;

    logic                   out_valid_reg;
    logic [FIELD_W-1:0]     out_proposer_reg;
    logic [FIELD_W-1:0]     out_partner_reg;
    logic                   out_unmatched_reg;
    logic                   out_last_reg;

    logic [FIELD_W-1:0]     pref_mem [DEPTH];
    logic [FIELD_W-1:0]     rank_mem [DEPTH];
    logic [FIELD_W-1:0]     pref_rd_q;
    logic [FIELD_W-1:0]     rank_p_q;
    logic [FIELD_W-1:0]     rank_r_q;

    logic                   pop;
    logic                   pref_we;
    logic                   rank_we;
    logic [ADDR_W-1:0]      pref_wr_addr;
    logic [ADDR_W-1:0]      rank_wr_addr;
    logic [ADDR_W-1:0]      pref_rd_addr;
    logic [ADDR_W-1:0]      rank_p_addr;
    logic [ADDR_W-1:0]      rank_r_addr;

    logic                   found;
    logic [IDX_W-1:0]       fp;
    logic [POS_W-1:0]       fpos;
    logic                   a_ok;
    logic [IDX_W-1:0]       a_idx;
    logic [IDX_W-1:0]       rival;
    logic [IDX_W-1:0]       emit_idx;
    logic                   emit_none;
    logic                   out_free;

    assign cmd_ready = (state_reg == S_IDLE);
    assign pop       = cmd_valid && cmd_ready;
    assign pref_we   = pop && (cmd.kind == REQ_LOAD_PREF);
    assign rank_we   = pop && (cmd.kind == REQ_LOAD_RANK);

    assign pref_wr_addr = ADDR_W'(int'(cmd.person) * NUM_PEOPLE + int'(cmd.rank));
    assign rank_wr_addr = ADDR_W'(int'(cmd.person) * NUM_PEOPLE + int'(cmd.choice));

    // lowest-numbered free proposer
    always_comb
    begin
        found = 1'b0;
        fp    = '0;
        for (int i = NUM_PEOPLE - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                found = 1'b1;
                fp    = IDX_W'(i);
            end
        end
    end

    assign fpos         = pos_reg[fp];
    assign pref_rd_addr = ADDR_W'(int'(fp) * NUM_PEOPLE + int'(fpos));

    assign a_ok        = (int'(pref_rd_q) < NUM_PEOPLE);
    assign a_idx       = IDX_W'(pref_rd_q);
    assign rival       = ap_reg[a_idx];
    assign rank_p_addr = ADDR_W'(int'(a_idx) * NUM_PEOPLE + int'(cur_p_reg));
    assign rank_r_addr = ADDR_W'(int'(a_idx) * NUM_PEOPLE + int'(rival));

    assign emit_idx  = IDX_W'(cnt_reg);
    assign emit_none = !pm_reg[emit_idx];
    assign out_free  = !out_valid_reg || pair.ready;

    always_ff @(posedge clk)
    begin
        if (pref_we)
        begin
            pref_mem[pref_wr_addr] <= cmd.choice;
        end
        if (rank_we)
        begin
            rank_mem[rank_wr_addr] <= cmd.rank;
        end
        pref_rd_q <= pref_mem[pref_rd_addr];
        rank_p_q  <= rank_mem[rank_p_addr];
        rank_r_q  <= rank_mem[rank_r_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            free_reg          <= '0;
            pm_reg            <= '0;
            ae_reg            <= '0;
            pp_reg            <= '{default: '0};
            ap_reg            <= '{default: '0};
            pos_reg           <= '{default: '0};
            cur_p_reg         <= '0;
            cur_a_reg         <= '0;
            rival_reg         <= '0;
            cnt_reg           <= '0;
            out_valid_reg     <= 1'b0;
            out_proposer_reg  <= '0;
            out_partner_reg   <= '0;
            out_unmatched_reg <= 1'b0;
            out_last_reg      <= 1'b0;
        end
        else
        begin
            // the emit state drives the valid flag itself
            if (out_valid_reg && pair.ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop && (cmd.kind == REQ_RUN))
                    begin
                        free_reg  <= '1;
                        pm_reg    <= '0;
                        ae_reg    <= '0;
                        pos_reg   <= '{default: '0};
                        state_reg <= S_FIND;
                    end
                end
                S_FIND:
                begin
                    if (!found)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (int'(fpos) >= NUM_PEOPLE)
                    begin
                        // list used up: drop out of the free set for good
                        free_reg[fp] <= 1'b0;
                    end
                    else
                    begin
                        pos_reg[fp] <= fpos + POS_W'(1);
                        cur_p_reg   <= fp;
                        state_reg   <= S_PREF;
                    end
                end
                S_PREF:
                begin
                    state_reg <= S_FIND;
                    if (a_ok)
                    begin
                        if (!ae_reg[a_idx])
                        begin
                            ae_reg[a_idx]    <= 1'b1;
                            ap_reg[a_idx]    <= cur_p_reg;
                            pm_reg[cur_p_reg] <= 1'b1;
                            pp_reg[cur_p_reg] <= a_idx;
                            free_reg[cur_p_reg] <= 1'b0;
                        end
                        else
                        begin
                            cur_a_reg <= a_idx;
                            rival_reg <= rival;
                            state_reg <= S_CMP;
                        end
                    end
                end
                S_CMP:
                begin
                    // ties keep the current partner
                    if (rank_p_q < rank_r_q)
                    begin
                        ap_reg[cur_a_reg]   <= cur_p_reg;
                        pm_reg[cur_p_reg]   <= 1'b1;
                        pp_reg[cur_p_reg]   <= cur_a_reg;
                        free_reg[cur_p_reg] <= 1'b0;
                        pm_reg[rival_reg]   <= 1'b0;
                        free_reg[rival_reg] <= 1'b1;
                    end
                    state_reg <= S_FIND;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_proposer_reg  <= FIELD_W'(cnt_reg);
                        out_partner_reg   <= emit_none ? '0 : FIELD_W'(pp_reg[emit_idx]);
                        out_unmatched_reg <= emit_none;
                        out_last_reg      <= (cnt_reg == CNT_W'(OUT_CNT - 1));
                        cnt_reg           <= cnt_reg + CNT_W'(1);
                        if (cnt_reg == CNT_W'(OUT_CNT - 1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign pair.valid     = out_valid_reg;
    assign pair.proposer  = out_proposer_reg;
    assign pair.partner   = out_partner_reg;
    assign pair.unmatched = out_unmatched_reg;
    assign pair.last_pair = out_last_reg;

endmodule

`default_nettype wire

### hdl/stable_matching_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Proposer-optimal stable matching over NUM_PEOPLE proposers and acceptors.
// Request beats load one proposer preference entry (type 0) or one acceptor
// rank entry (type 1), or start a run (type 2); out-of-range loads and type 3
// are dropped at the front. A two-entry command queue decouples the request
// side from the engine. Loads stream at one per cycle while no run is in
// progress. A run first clears the match state, then per proposal takes a
// find step, a preference-memory read step and, when the acceptor is already
// engaged, a rank-memory compare step (up to NUM_PEOPLE^2 proposals), plus an
// exhaust step for each proposer whose list runs out and a closing find step
// that sees no free proposer, then sends min(NUM_PEOPLE, 8) result beats at
// one per cycle while the sink is ready. The registered reads of the separate
// preference and rank memories set these proposal steps. Tables are undefined
// until written; no clearing pass follows reset.
module stable_matching_engine #(
    parameter int NUM_PEOPLE = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sme_req_if.sink     req,
    sme_pair_if.source  pair
);
    import sme_pkg::*;

    logic      cmd_valid;
    logic      cmd_ready;
    sme_cmd_t  cmd;

    sme_front #(
        .NUM_PEOPLE (NUM_PEOPLE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    sme_back #(
        .NUM_PEOPLE (NUM_PEOPLE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .pair      (pair)
    );

endmodule

`default_nettype wire

### hdl/sme_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sme_checker #(
    parameter int NUM_PEOPLE = 8
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       pair_valid,
    input wire logic       pair_ready,
    input wire logic [2:0] pair_proposer,
    input wire logic [2:0] pair_partner,
    input wire logic       pair_unmatched,
    input wire logic       pair_last_pair
);
    import sme_pkg::*;

    localparam int OUT_CNT = (NUM_PEOPLE < MAX_OUT) ? NUM_PEOPLE : MAX_OUT;

    logic beat;

    assign beat = pair_valid && pair_ready;

    // stalled result beat holds
    `SME_ASSERT_NXT(a_pair_hold, clk, rst_n, pair_valid && !pair_ready, pair_valid && $stable(pair_proposer) && $stable(pair_partner) && $stable(pair_unmatched) && $stable(pair_last_pair))

    // unmatched proposers report partner zero
    `SME_ASSERT_IMP(a_unmatched_zero, clk, rst_n, pair_valid && pair_unmatched, pair_partner == 3'd0)

    // the closing beat belongs to the last reported proposer
    `SME_ASSERT_IMP(a_last_index, clk, rst_n, pair_valid && pair_last_pair, pair_proposer == 3'(OUT_CNT - 1))

    // a new run cannot produce a beat right after the closing one
    `SME_ASSERT_NXT(a_gap_after_last, clk, rst_n, beat && pair_last_pair, !pair_valid)

endmodule

bind stable_matching_engine sme_checker #(
    .NUM_PEOPLE (NUM_PEOPLE)
) u_sme_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pair_valid     (pair.valid),
    .pair_ready     (pair.ready),
    .pair_proposer  (pair.proposer),
    .pair_partner   (pair.partner),
    .pair_unmatched (pair.unmatched),
    .pair_last_pair (pair.last_pair)
);

`default_nettype wire
